/* hdl/htpif_pkg.sv */
// Package for the linear-probing hash table with find and insert.
// Holds the mix constants, status codes, controller states and the
// command and status structs shared by the controller and the datapath.
`default_nettype none

package htpif_pkg;

   localparam int TABLE_SLOTS_DEF = 1024;
   localparam int KEY_W           = 64;
   localparam int SLOT_OUT_W      = 10;
   localparam int MIX_SHIFT       = 33;
   localparam logic [63:0] MIX_MUL_A = 64'hff51afd7ed558ccd;
   localparam logic [63:0] MIX_MUL_B = 64'hc4ceb9fe1a85ec53;

   // The modulo reduction sums one weighted hash byte a cycle, then forms the
   // quotient estimate and after it the remainder.
   localparam int RED_DIGIT_W = 8;
   localparam int RED_STEPS   = KEY_W / RED_DIGIT_W + 2;
   localparam int STEP_W      = $clog2(RED_STEPS);

   localparam logic OP_FIND   = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_DUPLICATE = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_MUL_A,
      S_MUL_B,
      S_REDUCE,
      S_HOME,
      S_FILL,
      S_PROBE,
      S_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic mul_step;
      logic mul_sel;
      logic reduce_step;
      logic load_home;
      logic advance;
      logic count_step;
      logic finish;
      logic clear_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic mul_last;
      logic red_last;
      logic hit_empty;
      logic hit_match;
      logic probe_last;
      logic clear_last;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

/* hdl/htpif_ctrl.sv */
// Controller state machine for the hash table: clearing pass, mixing,
// reduction, probing and result hand-off. Depends on htpif_pkg and drives
// the datapath only through cmd_type and stat_type.
`default_nettype none

module htpif_ctrl
   import htpif_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_MUL_A;
         end
         S_MUL_A: begin
            if (stat.mul_last) state_in = S_MUL_B;
         end
         S_MUL_B: begin
            if (stat.mul_last) state_in = S_REDUCE;
         end
         S_REDUCE: begin
            if (stat.red_last) state_in = S_HOME;
         end
         S_HOME: begin
            state_in = S_FILL;
         end
         S_FILL: begin
            state_in = S_PROBE;
         end
         S_PROBE: begin
            if (stat.hit_empty || stat.hit_match || stat.probe_last) state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         S_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         S_MUL_A: begin
            cmd.mul_step = 1'b1;
         end
         S_MUL_B: begin
            cmd.mul_step = 1'b1;
            cmd.mul_sel  = 1'b1;
         end
         S_REDUCE: begin
            cmd.reduce_step = 1'b1;
         end
         S_HOME: begin
            cmd.load_home = 1'b1;
         end
         S_FILL: begin
            cmd.advance = 1'b1;
         end
         S_PROBE: begin
            cmd.advance    = 1'b1;
            cmd.count_step = 1'b1;
            cmd.finish     = stat.hit_empty || stat.hit_match || stat.probe_last;
         end
         S_DONE: begin
            cmd.load_out = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

/* hdl/htpif_datapath.sv */
// Datapath for the hash table: key mix with one shared 32x32 multiplier,
// modulo reduction, slot memory with registered read, probe pointer and
// result registers. Depends on htpif_pkg and is sequenced by htpif_ctrl.
`default_nettype none

module htpif_datapath
   import htpif_pkg::*;
#(
   parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           cmd,
   output stat_type               stat,
   input  wire logic              req_operation,
   input  wire logic signed [63:0] req_key,
   input  wire logic              rsp_stall,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic [SLOT_OUT_W-1:0]  rsp_slot_index
);

   localparam int SLOT_W = $clog2(TABLE_SLOTS);
   localparam int SUM_W  = SLOT_W + 11;
   localparam int Q_W    = 12;
   localparam bit IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
   localparam logic [SUM_W-1:0] MOD_N = SUM_W'(TABLE_SLOTS);
   localparam logic [SUM_W-1:0] RECIP = SUM_W'((1 << SUM_W) / TABLE_SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
   localparam logic [STEP_W-1:0] MUL_LAST_STEP = STEP_W'(2);
   localparam logic [STEP_W-1:0] QUOT_STEP = STEP_W'(RED_STEPS - 2);
   localparam logic [STEP_W-1:0] RED_LAST_STEP = STEP_W'(RED_STEPS - 1);

   function automatic logic [7:0][SLOT_W-1:0] byte_weights();
      logic [7:0][SLOT_W-1:0] w;
      int r;
      r = 1 % TABLE_SLOTS;
      for (int i = 0; i < 8; i++) begin
         w[i] = SLOT_W'(r);
         r = (r * 256) % TABLE_SLOTS;
      end
      return w;
   endfunction

   localparam logic [7:0][SLOT_W-1:0] BYTE_WEIGHT = byte_weights();

   logic              op_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [KEY_W-1:0]  x_ff;
   logic [KEY_W-1:0]  acc_ff;
   logic [STEP_W-1:0] step_ff;
   logic [SLOT_W-1:0] rem_ff;
   logic [SUM_W-1:0]  red_sum_ff;
   logic [Q_W-1:0]    red_q_ff;
   logic [SLOT_W-1:0] probe_addr_ff;
   logic [SLOT_W-1:0] eval_addr_ff;
   logic [SLOT_W-1:0] count_ff;
   logic [KEY_W:0]    rd_data_ff;
   status_type        res_status_ff;
   logic [SLOT_W-1:0] res_slot_ff;
   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff;

   logic [KEY_W:0]    mem [TABLE_SLOTS];

   logic [KEY_W-1:0]  key_in;
   logic [KEY_W-1:0]  mul_const;
   logic [31:0]       mul_a;
   logic [31:0]       mul_b;
   logic [63:0]       pp;
   logic [KEY_W-1:0]  acc_in;
   logic [KEY_W-1:0]  mixed;
   logic [SLOT_W-1:0] red_weight;
   logic [SLOT_W+7:0] red_term;
   logic [SUM_W-1:0]  red_sum_in;
   logic [2*SUM_W-1:0] red_prod;
   logic [Q_W-1:0]    red_q_in;
   logic [SUM_W-1:0]  red_qn;
   logic [SUM_W-1:0]  red_diff;
   logic [SUM_W-1:0]  red_rem;
   logic [SLOT_W-1:0] rem_in;
   logic [SLOT_W-1:0] probe_next;
   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   logic [KEY_W:0]    wr_data;
   status_type        res_status_in;
   logic [SLOT_W-1:0] res_slot_in;
   logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;

   assign key_in = $unsigned(req_key);

   // Low 64 bits of x times the constant, one 32x32 partial product a step.
   always_comb begin
      mul_const = cmd.mul_sel ? MIX_MUL_B : MIX_MUL_A;
      mul_a     = (step_ff == STEP_W'(1)) ? x_ff[63:32] : x_ff[31:0];
      mul_b     = (step_ff == MUL_LAST_STEP) ? mul_const[63:32] : mul_const[31:0];
      pp        = {32'b0, mul_a} * {32'b0, mul_b};
      if (step_ff == '0) begin
         acc_in = pp;
      end else begin
         acc_in = acc_ff + {pp[31:0], 32'b0};
      end
      mixed = acc_in ^ (acc_in >> MIX_SHIFT);
   end

   // Remainder by the table size: the hash bytes weighted by their place modulo
   // the size are summed, and the sum is reduced with a truncated reciprocal.
   always_comb begin
      red_weight = BYTE_WEIGHT[step_ff[2:0]];
      red_term   = (SLOT_W + 8)'(x_ff[RED_DIGIT_W-1:0]) * (SLOT_W + 8)'(red_weight);
      red_sum_in = red_sum_ff + SUM_W'(red_term);
      red_prod   = (2 * SUM_W)'(red_sum_ff) * (2 * SUM_W)'(RECIP);
      red_q_in   = red_prod[SUM_W +: Q_W];
      red_qn     = SUM_W'(red_q_ff) * MOD_N;
      red_diff   = red_sum_ff - red_qn;
      red_rem    = (red_diff >= MOD_N) ? red_diff - MOD_N : red_diff;
      rem_in     = IS_POW2 ? x_ff[SLOT_W-1:0] : red_rem[SLOT_W-1:0];
   end

   assign probe_next = (probe_addr_ff == LAST_SLOT) ? '0 : probe_addr_ff + 1'b1;

   always_comb begin
      stat.mul_last   = step_ff == MUL_LAST_STEP;
      stat.red_last   = IS_POW2 || (step_ff == RED_LAST_STEP);
      stat.hit_empty  = !rd_data_ff[KEY_W];
      stat.hit_match  = rd_data_ff[KEY_W] && (rd_data_ff[KEY_W-1:0] == key_ff);
      stat.probe_last = count_ff == LAST_SLOT;
      stat.clear_last = probe_addr_ff == LAST_SLOT;
      stat.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      if (stat.hit_empty) begin
         res_status_in = (op_ff == OP_INSERT) ? ST_OK : ST_NOT_FOUND;
         res_slot_in   = (op_ff == OP_INSERT) ? eval_addr_ff : '0;
      end else if (stat.hit_match) begin
         res_status_in = (op_ff == OP_INSERT) ? ST_DUPLICATE : ST_OK;
         res_slot_in   = eval_addr_ff;
      end else begin
         res_status_in = (op_ff == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
         res_slot_in   = '0;
      end
   end

   always_comb begin
      wr_en   = cmd.clear_step || (cmd.finish && stat.hit_empty && (op_ff == OP_INSERT));
      wr_addr = cmd.clear_step ? probe_addr_ff : eval_addr_ff;
      wr_data = cmd.clear_step ? '0 : {1'b1, key_ff};
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff   <= mem[probe_addr_ff];
      eval_addr_ff <= probe_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_operation;
         key_ff     <= key_in;
         x_ff       <= key_in ^ (key_in >> MIX_SHIFT);
         step_ff    <= '0;
         rem_ff     <= '0;
         red_sum_ff <= '0;
      end else if (cmd.mul_step) begin
         if (stat.mul_last) begin
            x_ff    <= mixed;
            step_ff <= '0;
         end else begin
            acc_ff  <= acc_in;
            step_ff <= step_ff + 1'b1;
         end
      end else if (cmd.reduce_step) begin
         step_ff <= step_ff + 1'b1;
         if (stat.red_last) begin
            rem_ff <= rem_in;
         end else if (step_ff == QUOT_STEP) begin
            red_q_ff <= red_q_in;
         end else begin
            red_sum_ff <= red_sum_in;
            x_ff       <= x_ff >> RED_DIGIT_W;
         end
      end
      if (cmd.finish) begin
         res_status_ff <= res_status_in;
         res_slot_ff   <= res_slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_addr_ff <= '0;
         count_ff      <= '0;
      end else if (cmd.load_home) begin
         probe_addr_ff <= rem_ff;
         count_ff      <= '0;
      end else begin
         if (cmd.advance || cmd.clear_step) probe_addr_ff <= probe_next;
         if (cmd.count_step) count_ff <= count_ff + 1'b1;
      end
   end

   assign slot_ext = {{SLOT_OUT_W{1'b0}}, res_slot_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load_out) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= slot_ext[SLOT_OUT_W-1:0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_slot_ff;

endmodule

`default_nettype wire

/* hdl/hash_table_probe_insert_find.sv */
// Top level of the linear-probing hash table with find and insert.
// Instantiates htpif_ctrl and htpif_datapath; depends on htpif_pkg.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_stall   req_operation, req_key
//   rsp       out        rsp_valid/rsp_stall   rsp_status, rsp_slot_index
//
// From acceptance to its result a word passes through two mixing rounds on
// the shared 32x32 multiplier, the remainder steps (only when the table size
// is not a power of two) and the probe of each slot it visits. A new request
// word is taken only once the previous result is in the output register.
// After reset a clearing pass writes every slot with req_stall high. A
// stalled result holds in the output register while the next request is
// already accepted.
`default_nettype none

module hash_table_probe_insert_find
   import htpif_pkg::*;
#(
   parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_operation,
   input  wire logic signed [63:0]    req_key,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [1:0]                 rsp_status,
   output logic [SLOT_OUT_W-1:0]      rsp_slot_index
);

   cmd_type  cmd;
   stat_type stat;

   htpif_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   htpif_datapath #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_operation  (req_operation),
      .req_key        (req_key),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_slot_index (rsp_slot_index)
   );

endmodule

`default_nettype wire
